[rtl/sie_pkg.sv]
// Shared types, constants and helpers for the save icon extractor.
// No dependencies; used by every rtl module of the block.
package sie_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int POS_W         = 11;
    localparam int REL_W         = 9;
    localparam int SLOT_W        = $clog2(PALETTE_DEPTH);

    localparam logic [POS_W-1:0] POS_MAX       = 11'h7FF;
    localparam logic [POS_W-1:0] POS_DESC_END  = 11'h010;
    localparam logic [POS_W-1:0] POS_COUNT_LO  = 11'h040;
    localparam logic [POS_W-1:0] POS_COUNT_HI  = 11'h041;
    localparam logic [POS_W-1:0] POS_PAL_START = 11'h060;
    localparam logic [POS_W-1:0] POS_PAL_END   = 11'h080;
    localparam logic [REL_W-2:0] FRAME_BASE_LO = 8'h80;
    localparam logic [POS_W:0]   FRAME_BYTES   = 12'd512;
    localparam logic [POS_W:0]   MIN_SIZE      = 12'h042;

    // ink when 17*(299r + 587g + 114b) < 65000, nibble-level sum
    localparam logic [13:0] INK_SUM_MAX = 14'd3823;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_DESC = 2'd1,
        OP_PAL  = 2'd2,
        OP_PIX  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DESC   = 2'd0,
        KIND_PAL    = 2'd1,
        KIND_PIX    = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_SHORT     = 2'd3
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [15:0]      data;
        logic [REL_W-1:0] idx;
        logic             last;
        status_t          status;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  desc_byte;
        logic [3:0]  palette_index;
        logic [15:0] palette_entry;
        logic [9:0]  pixel_index;
        logic [3:0]  left_color;
        logic [3:0]  right_color;
        logic        mono_valid;
        logic [7:0]  mono_byte;
        logic [6:0]  mono_index;
        status_t     status;
        logic        last_result;
    } result_t;

    function automatic logic entry_is_ink(input logic [15:0] entry);
        logic [13:0] sum;
        begin
            sum = entry[11:8] * 14'd299 + entry[7:4] * 14'd587
                + entry[3:0] * 14'd114;
            entry_is_ink = (entry[15:12] != 4'd0) && (sum <= INK_SUM_MAX);
        end
    endfunction

endpackage

[rtl/sie_front.sv]
// Front end: accepts file bytes, tracks file position, icon count and status,
// and classifies each item into a command. Depends on sie_pkg.
module sie_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            frame_select_we,
    input  logic [1:0]      frame_select,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            push,
    output sie_pkg::cmd_t   cmd
);

    logic [sie_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                count_low_reg, count_low_next;
    logic [1:0]                icon_count_reg, icon_count_next;
    logic [7:0]                pal_lo_reg, pal_lo_next;
    logic [1:0]                fsel_reg;

    logic [sie_pkg::POS_W-1:0] off;
    logic [sie_pkg::POS_W:0]   pos_w, off_end, size;
    logic [sie_pkg::POS_W-1:0] rel_full;
    logic                      frame_ok, in_frame;
    logic [1:0]                count_new, count_eff;

    always_comb
    begin
        off       = {fsel_reg, 1'b0, sie_pkg::FRAME_BASE_LO};
        pos_w     = {1'b0, pos_reg};
        off_end   = {1'b0, off} + sie_pkg::FRAME_BYTES;
        size      = pos_w + 12'd1;
        rel_full  = pos_reg - off;
        frame_ok  = (icon_count_reg != 2'd0) && (fsel_reg < icon_count_reg);
        in_frame  = frame_ok && (pos_reg >= off) && (pos_w < off_end);
        count_new = (data_byte == 8'd0 && count_low_reg[7:2] == 6'd0) ?
                    count_low_reg[1:0] : 2'd0;
        count_eff = (pos_reg == sie_pkg::POS_COUNT_HI) ? count_new : icon_count_reg;

        count_low_next  = count_low_reg;
        icon_count_next = icon_count_reg;
        pal_lo_next     = pal_lo_reg;
        cmd.op          = sie_pkg::OP_NONE;
        cmd.data        = {8'd0, data_byte};
        cmd.idx         = '0;
        cmd.last        = last_byte;

        priority if (pos_reg < sie_pkg::POS_DESC_END)
        begin
            cmd.op = sie_pkg::OP_DESC;
        end
        else if (pos_reg == sie_pkg::POS_COUNT_LO)
        begin
            count_low_next = data_byte;
        end
        else if (pos_reg == sie_pkg::POS_COUNT_HI)
        begin
            icon_count_next = count_new;
        end
        else if (pos_reg >= sie_pkg::POS_PAL_START && pos_reg < sie_pkg::POS_PAL_END)
        begin
            if (pos_reg[0] == 1'b0)
            begin
                pal_lo_next = data_byte;
            end
            else
            begin
                cmd.op   = sie_pkg::OP_PAL;
                cmd.data = {data_byte, pal_lo_reg};
                cmd.idx  = {{(sie_pkg::REL_W-sie_pkg::SLOT_W){1'b0}}, pos_reg[4:1]};
            end
        end
        else if (in_frame)
        begin
            cmd.op  = sie_pkg::OP_PIX;
            cmd.idx = rel_full[sie_pkg::REL_W-1:0];
        end
        else
        begin
            cmd.op = sie_pkg::OP_NONE;
        end

        priority if (size < sie_pkg::MIN_SIZE || count_eff == 2'd0)
            cmd.status = sie_pkg::ST_BAD_COUNT;
        else if (fsel_reg >= count_eff)
            cmd.status = sie_pkg::ST_ABSENT;
        else if (size < off_end)
            cmd.status = sie_pkg::ST_SHORT;
        else
            cmd.status = sie_pkg::ST_OK;

        if (last_byte)
        begin
            pos_next        = '0;
            count_low_next  = '0;
            icon_count_next = '0;
        end
        else if (pos_reg != sie_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 11'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end

        push = accept && (cmd.op != sie_pkg::OP_NONE || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            count_low_reg  <= '0;
            icon_count_reg <= '0;
            fsel_reg       <= '0;
        end
        else
        begin
            if (frame_select_we)
                fsel_reg <= frame_select;
            if (accept)
            begin
                pos_reg        <= pos_next;
                count_low_reg  <= count_low_next;
                icon_count_reg <= icon_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pal_lo_reg <= pal_lo_next;
    end

endmodule

[rtl/sie_fifo.sv]
// Two-entry command queue between front and back ends.
// Depends on sie_pkg for the command type.
module sie_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sie_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output sie_pkg::cmd_t head
);

    sie_pkg::cmd_t mem [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/sie_back.sv]
// Back end: executes queued commands, keeps per-slot ink flags and the mono
// accumulator, and drives the registered result item. Depends on sie_pkg.
module sie_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  sie_pkg::cmd_t    head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output sie_pkg::result_t result
);

    logic [sie_pkg::PALETTE_DEPTH-1:0] ink_reg;
    logic [7:0]                        acc_reg, acc_next, acc_new;
    logic                              phase_reg, phase_next;
    logic                              out_valid_reg, out_valid_next;
    sie_pkg::result_t                  res_reg, res_next;

    logic out_free, has_pri, emit_pri, emit_stat;
    logic ink_l, ink_r;

    always_comb
    begin
        out_free  = !out_valid_reg || result_ready;
        has_pri   = (head.op != sie_pkg::OP_NONE);
        emit_pri  = head_valid && out_free && has_pri && !phase_reg;
        emit_stat = head_valid && out_free && head.last && (phase_reg || !has_pri);
        pop       = emit_stat || (emit_pri && !head.last);

        ink_l   = ink_reg[head.data[7:4]];
        ink_r   = ink_reg[head.data[3:0]];
        acc_new = {acc_reg[5:0], ink_l, ink_r};

        res_next   = '0;
        acc_next   = acc_reg;
        phase_next = phase_reg;

        if (emit_stat)
        begin
            res_next.kind        = sie_pkg::KIND_STATUS;
            res_next.status      = head.status;
            res_next.last_result = 1'b1;
            acc_next             = '0;
            phase_next           = 1'b0;
        end
        else if (emit_pri)
        begin
            phase_next = head.last;
            unique case (head.op)
                sie_pkg::OP_DESC:
                begin
                    res_next.kind      = sie_pkg::KIND_DESC;
                    res_next.desc_byte = head.data[7:0];
                end
                sie_pkg::OP_PAL:
                begin
                    res_next.kind          = sie_pkg::KIND_PAL;
                    res_next.palette_index = head.idx[sie_pkg::SLOT_W-1:0];
                    res_next.palette_entry = head.data;
                end
                sie_pkg::OP_PIX:
                begin
                    res_next.kind        = sie_pkg::KIND_PIX;
                    res_next.pixel_index = {head.idx, 1'b0};
                    res_next.left_color  = head.data[7:4];
                    res_next.right_color = head.data[3:0];
                    acc_next             = acc_new;
                    if (head.idx[1:0] == 2'd3)
                    begin
                        res_next.mono_valid = 1'b1;
                        res_next.mono_byte  = acc_new;
                        res_next.mono_index = head.idx[sie_pkg::REL_W-1:2];
                        acc_next            = '0;
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end

        if (emit_pri || emit_stat)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_pri || emit_stat)
            res_reg <= res_next;
        if (emit_pri && head.op == sie_pkg::OP_PAL)
            ink_reg[head.idx[sie_pkg::SLOT_W-1:0]] <= sie_pkg::entry_is_ink(head.data);
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

endmodule

[rtl/save_icon_extractor.sv]
// Top level of the save icon extractor: front end, command queue, back end.
// Depends on sie_pkg, sie_front, sie_fifo and sie_back.
//
//   port group        handshake                       payload
//   file bytes        data_valid / data_ready         data_byte, last_byte
//   results           result_valid / result_ready     kind ... last_result
//   frame select      frame_select_we                 frame_select
//
// One byte per cycle sustained while results are taken; the last byte of a file that
// also carries a description, palette or pixel result takes an extra back-end step.
// A result is registered in the queue when its byte is accepted, then in the
// output register once the result port is free to take it.
// Reset clears position, count, queue and output state; ink flags are loaded
// by palette bytes. A stalled result port fills the two-entry queue, then
// data_ready drops.
module save_icon_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_select_we,
    input  logic [1:0]  frame_select,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [7:0]  desc_byte,
    output logic [3:0]  palette_index,
    output logic [15:0] palette_entry,
    output logic [9:0]  pixel_index,
    output logic [3:0]  left_color,
    output logic [3:0]  right_color,
    output logic        mono_valid,
    output logic [7:0]  mono_byte,
    output logic [6:0]  mono_index,
    output logic [1:0]  status,
    output logic        last_result
);

    logic             accept, push, pop, full, empty;
    sie_pkg::cmd_t    push_cmd, head;
    sie_pkg::result_t result;

    assign data_ready = !full;
    assign accept     = data_valid && !full;

    sie_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_select_we (frame_select_we),
        .frame_select    (frame_select),
        .accept          (accept),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .push            (push),
        .cmd             (push_cmd)
    );

    sie_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    sie_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign kind          = result.kind;
    assign desc_byte     = result.desc_byte;
    assign palette_index = result.palette_index;
    assign palette_entry = result.palette_entry;
    assign pixel_index   = result.pixel_index;
    assign left_color    = result.left_color;
    assign right_color   = result.right_color;
    assign mono_valid    = result.mono_valid;
    assign mono_byte     = result.mono_byte;
    assign mono_index    = result.mono_index;
    assign status        = result.status;
    assign last_result   = result.last_result;

endmodule
